>>> hw/rtl/ssp_pkg.sv
package ssp_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int ANGLE_W   = 11;
    localparam int POS_W     = 8;
    localparam int DUTY_W    = 25;
    localparam int DELAY_W   = 16;
    localparam int OFFSET_W  = 9;
    localparam int STEP_W    = 26;
    localparam int CFG_IDX_W = 2;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // item kinds carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ABS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REL  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_DELAY = 2'd3;

    // register reset values
    localparam logic [DUTY_W-1:0]  MIN_DUTY_RST       = 25'd500000;
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST       = 25'd2500000;
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST     = 16'd15;
    localparam logic [DELAY_W-1:0] MIN_STEP_DELAY_RST = 16'd10;

    // cycles for the duty step pipeline to settle after a change
    localparam logic [1:0] STEP_SETTLE = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]           current_angle;
        logic [DUTY_W-1:0]          duty_ns;
        logic                       busy_res;
        logic signed [OFFSET_W-1:0] applied_offset;
        logic                       clamped;
    } ssp_result_t;

endpackage

>>> hw/rtl/ssp_step_div.sv
module ssp_step_div
    import ssp_pkg::*;
#(
    parameter int DIVISOR = 170
) (
    input  logic                     aclk,
    input  logic [DUTY_W-1:0]        min_duty,
    input  logic [DUTY_W-1:0]        max_duty,
    output logic signed [STEP_W-1:0] duty_step
);

    // reciprocal scaled so the first quotient estimate is low by at most one
    localparam int SHIFT  = DUTY_W + $clog2(DIVISOR);
    localparam int RECIP_W = DUTY_W + 1;
    localparam int PROD_W = DUTY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIVISOR);
    localparam logic [DUTY_W-1:0]  DIV_C = DUTY_W'(DIVISOR);

    logic [DUTY_W:0]         diff;
    logic                    neg_d1_reg, neg_d2_reg;
    logic [DUTY_W-1:0]       mag_next, mag_d1_reg, mag_d2_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DUTY_W-1:0]       quot_est;
    logic [2*DUTY_W-1:0]     quot_mul;
    logic [DUTY_W-1:0]       rem;
    logic [DUTY_W-1:0]       quot;
    logic [STEP_W-1:0]       step_next;
    logic signed [STEP_W-1:0] step_reg;

    // sign and magnitude of the duty span
    always_comb begin
        diff     = {1'b0, max_duty} - {1'b0, min_duty};
        mag_next = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];
    end

    // magnitude times reciprocal
    always_ff @(posedge aclk) begin
        neg_d1_reg <= diff[DUTY_W];
        mag_d1_reg <= mag_next;
        neg_d2_reg <= neg_d1_reg;
        mag_d2_reg <= mag_d1_reg;
        prod_reg   <= PROD_W'(mag_d1_reg) * PROD_W'(RECIP);
    end

    // correct the estimate by one and restore the sign
    always_comb begin
        quot_est  = DUTY_W'(prod_reg >> SHIFT);
        quot_mul  = (2*DUTY_W)'(quot_est) * (2*DUTY_W)'(DIV_C);
        rem       = mag_d2_reg - quot_mul[DUTY_W-1:0];
        quot      = (rem >= DIV_C) ? quot_est + 1'b1 : quot_est;
        step_next = neg_d2_reg ? STEP_W'(-{1'b0, quot}) : STEP_W'({1'b0, quot});
    end

    always_ff @(posedge aclk) begin
        step_reg <= signed'(step_next);
    end

    assign duty_step = step_reg;

endmodule

>>> hw/rtl/ssp_core.sv
module ssp_core
    import ssp_pkg::*;
#(
    parameter int FULL_ANGLE = 170
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic [DELAY_W-1:0]       eff_delay,
    input  logic signed [STEP_W-1:0] duty_step,
    input  logic [DUTY_W-1:0]        min_duty,
    output ssp_result_t              result
);

    localparam logic [POS_W-1:0] FULL = POS_W'(FULL_ANGLE);
    localparam int CALC_W = ANGLE_W + 1;
    localparam int PROD_W = STEP_W + POS_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic [POS_W-1:0]   position_reg, position_next;
    logic [POS_W-1:0]   target_reg, target_next;
    logic [DELAY_W-1:0] countdown_reg, countdown_next;
    logic               moving_reg, moving_next;

    logic signed [CALC_W-1:0]   ang_ext, pos_ext, full_ext, headroom, rel_sum;
    logic signed [OFFSET_W-1:0] applied;
    logic                       clamp;
    logic signed [PROD_W-1:0]   duty_prod;
    logic signed [SUM_W-1:0]    duty_sum;

    // operands for the relative and absolute checks
    always_comb begin
        ang_ext  = CALC_W'(angle);
        pos_ext  = signed'(CALC_W'(position_reg));
        full_ext = signed'(CALC_W'(FULL));
        headroom = full_ext - pos_ext;
        rel_sum  = ang_ext + pos_ext;
    end

    // next state for one item
    always_comb begin
        position_next  = position_reg;
        target_next    = target_reg;
        countdown_next = countdown_reg;
        moving_next    = moving_reg;
        applied        = '0;
        clamp          = 1'b0;
        case (mode)
            MODE_TICK: begin
                if (moving_reg) begin
                    if (countdown_reg <= DELAY_W'(1)) begin
                        if (position_reg != target_reg) begin
                            position_next  = (position_reg > target_reg) ?
                                             position_reg - 1'b1 : position_reg + 1'b1;
                            countdown_next = eff_delay;
                        end else begin
                            countdown_next = '0;
                            moving_next    = 1'b0;
                        end
                    end else begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
            end
            MODE_ABS: begin
                // negative angles read as huge values and clamp high
                if (angle[ANGLE_W-1] || ang_ext > full_ext) begin
                    target_next = FULL;
                    clamp       = 1'b1;
                end else begin
                    target_next = angle[POS_W-1:0];
                end
                countdown_next = eff_delay;
                moving_next    = 1'b1;
            end
            MODE_REL: begin
                if (ang_ext > headroom) begin
                    target_next = FULL;
                    applied     = headroom[OFFSET_W-1:0];
                    clamp       = 1'b1;
                end else if (rel_sum < 0) begin
                    target_next = '0;
                    applied     = OFFSET_W'(-pos_ext);
                    clamp       = 1'b1;
                end else begin
                    target_next = rel_sum[POS_W-1:0];
                    applied     = ang_ext[OFFSET_W-1:0];
                end
                countdown_next = eff_delay;
                moving_next    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // duty for the new position, negative values floor at zero
    always_comb begin
        duty_prod = duty_step * signed'(PROD_W'({1'b0, position_next}));
        duty_sum  = SUM_W'(duty_prod) + signed'(SUM_W'(min_duty));
    end

    always_comb begin
        result.current_angle  = position_next;
        result.duty_ns        = duty_sum[SUM_W-1] ? '0 : duty_sum[DUTY_W-1:0];
        result.busy_res       = moving_next;
        result.applied_offset = applied;
        result.clamped        = clamp;
    end

    // servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            target_reg    <= '0;
            countdown_reg <= '0;
            moving_reg    <= 1'b0;
        end else if (advance) begin
            position_reg  <= position_next;
            target_reg    <= target_next;
            countdown_reg <= countdown_next;
            moving_reg    <= moving_next;
        end
    end

endmodule

>>> hw/rtl/servo_slew_position_controller_top.sv
// Servo angle ramp with a limited slew rate.
// Input stream: s_tuser carries the item kind (tick, absolute command,
// relative command), s_tdata carries the angle or offset in degrees.
// Each accepted beat gives exactly one result beat on the m_ side with the
// angle after that item, its pulse width, the busy flag, the offset a
// relative command actually applied and whether its target was clamped.
// From input beat to result beat an item passes the input register, the
// state update and duty multiply-add, then the result register.
// Throughput is one beat per cycle when not stalled or settling; the state
// update is a single pass. The result register frees as it is taken, so a
// stall on m_tready only stops input once both registers are full.
// Configuration writes go through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready. A write to either duty register restarts the pipeline
// that derives the duty step per degree; s_tready stays low until it has
// settled. The same hold applies after reset before the first input beat
// is taken. Reset puts the angle, target and timer at zero and loads the
// default register values.
module servo_slew_position_controller_top
    import ssp_pkg::*;
#(
    parameter int FULL_ANGLE = 170
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [10:0] angle, rest zero
    input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] current_angle, [32:8] duty_ns,
                                             // [33] busy_res, [42:34] applied_offset,
                                             // [43] clamped, rest zero

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DUTY_W-1:0]     cfg_data
);

    logic [DUTY_W-1:0]  min_duty_reg, max_duty_reg;
    logic [DELAY_W-1:0] step_delay_reg, min_step_delay_reg;
    logic [DELAY_W-1:0] eff_delay;
    logic [1:0]         settle_reg;
    logic               cfg_wr;

    logic                      in_valid_reg;
    logic [MODE_W-1:0]         in_mode_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic                      out_valid_reg;
    ssp_result_t               out_reg;
    ssp_result_t               result;
    logic                      out_free, advance, in_take;
    logic signed [STEP_W-1:0]  duty_step;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duty_reg       <= MIN_DUTY_RST;
            max_duty_reg       <= MAX_DUTY_RST;
            step_delay_reg     <= STEP_DELAY_RST;
            min_step_delay_reg <= MIN_STEP_DELAY_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_MIN_DUTY:       min_duty_reg       <= cfg_data;
                REG_MAX_DUTY:       max_duty_reg       <= cfg_data;
                REG_STEP_DELAY:     step_delay_reg     <= cfg_data[DELAY_W-1:0];
                REG_MIN_STEP_DELAY: min_step_delay_reg <= cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign eff_delay = (step_delay_reg < min_step_delay_reg) ? min_step_delay_reg
                                                              : step_delay_reg;

    // hold off input while the duty step settles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= STEP_SETTLE;
        end else if (cfg_wr && (cfg_index == REG_MIN_DUTY || cfg_index == REG_MAX_DUTY)) begin
            settle_reg <= STEP_SETTLE;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    ssp_step_div #(
        .DIVISOR (FULL_ANGLE)
    ) u_step_div (
        .aclk      (aclk),
        .min_duty  (min_duty_reg),
        .max_duty  (max_duty_reg),
        .duty_step (duty_step)
    );

    // handshake between the two stages
    assign out_free = ~out_valid_reg | m_tready;
    assign advance  = in_valid_reg & out_free;
    assign s_tready = (~in_valid_reg | advance) & (settle_reg == 2'd0);
    assign in_take  = s_tvalid & s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mode_reg  <= s_tuser;
            in_angle_reg <= signed'(s_tdata[ANGLE_W-1:0]);
        end
    end

    ssp_core #(
        .FULL_ANGLE (FULL_ANGLE)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .mode      (in_mode_reg),
        .angle     (in_angle_reg),
        .eff_delay (eff_delay),
        .duty_step (duty_step),
        .min_duty  (min_duty_reg),
        .result    (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.clamped, out_reg.applied_offset,
                                  out_reg.busy_res, out_reg.duty_ns,
                                  out_reg.current_angle});

endmodule

>>> hw/rtl/ssp_checker.sv
module ssp_checker
    import ssp_pkg::*;
#(
    parameter int FULL_ANGLE = 170
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [POS_W-1:0] last_angle_reg;
    logic [POS_W-1:0] beat_angle;
    logic             beat;

    assign beat_angle = m_tdata[7:0];
    assign beat       = m_tvalid & m_tready;

    // angle of the last delivered beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_angle_reg <= '0;
        end else if (beat) begin
            last_angle_reg <= beat_angle;
        end
    end

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the angle never leaves its range
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> beat_angle <= POS_W'(FULL_ANGLE))
        else $error("angle out of range");

    // slew limit: one degree per item at most
    a_slew: assert property (@(posedge aclk) disable iff (!aresetn)
        beat |-> (beat_angle == last_angle_reg) ||
                 (beat_angle == last_angle_reg + 8'd1) ||
                 (beat_angle == last_angle_reg - 8'd1))
        else $error("angle moved more than one degree");

    // a command always leaves the block busy
    a_cmd_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[33] |-> m_tdata[42:34] == 9'd0 && !m_tdata[43])
        else $error("command result while idle");

endmodule

bind servo_slew_position_controller_top ssp_checker #(
    .FULL_ANGLE (FULL_ANGLE)
) u_ssp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
